>>> rtl/zmodem_subpacket_receiver_defines.svh
// assertion macros for the receiver rtl
`ifndef ZMODEM_SUBPACKET_RECEIVER_DEFINES_SVH
`define ZMODEM_SUBPACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ZSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ZSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/zsr_pkg.sv
package zsr_pkg;

	localparam int MAX_PAYLOAD = 8192;
	localparam int CNT_W       = 14;
	localparam int FUNC_W      = 3;
	localparam int KIND_W      = 3;
	localparam int END_W       = 2;

	localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
	localparam logic [31:0] RESIDUE32  = 32'hDEBB_20E3;
	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam logic [7:0]  MARK_BASE  = 8'h68;

	localparam logic [CNT_W-1:0] MAX_PAYLOAD_C = CNT_W'(MAX_PAYLOAD);
	localparam logic [CNT_W-1:0] MAX_LENGTH_RST = CNT_W'(1024);

	typedef enum logic [FUNC_W-1:0] {
		FN_DATA    = 3'd0,
		FN_END     = 3'd1,
		FN_CANCEL  = 3'd2,
		FN_TIMEOUT = 3'd3,
		FN_CARRIER = 3'd4,
		FN_OTHER   = 3'd5
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		K_PAYLOAD  = 3'd0,
		K_END_OK   = 3'd1,
		K_CRC_ERR  = 3'd2,
		K_CANCEL   = 3'd3,
		K_TIMEOUT  = 3'd4,
		K_CARRIER  = 3'd5,
		K_DEBRIS   = 3'd6,
		K_TOO_LONG = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_DATA  = 3'b010,
		PH_TRAIL = 3'b100
	} phase_t;

endpackage

>>> rtl/zsr_if.sv
interface zsr_tok_if import zsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [7:0]        value;
	logic [END_W-1:0]  end_type;
	logic              use_crc32;

	modport source (output valid, func, value, end_type, use_crc32, input ready);
	modport sink (input valid, func, value, end_type, use_crc32, output ready);
endinterface

interface zsr_res_if import zsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [7:0]        data_byte;
	logic [END_W-1:0]  frame_end;
	logic [CNT_W-1:0]  byte_count;
	logic              last;

	modport source (output valid, kind, data_byte, frame_end, byte_count, last, input ready);
	modport sink (input valid, kind, data_byte, frame_end, byte_count, last, output ready);
endinterface

>>> rtl/zmodem_subpacket_receiver.sv
// ZMODEM data subpacket receiver. Takes one ZDLE-decoded token per beat on tok and
// gives at most one result beat per token on res: every payload byte is passed on
// (kind payload, last 0) and folded into the running CRC, and the subpacket closes
// with one beat with last 1 that carries the status, the end type of a good frame and
// the payload byte count. The CRC mode (CRC-16/XMODEM or reflected CRC-32) is taken
// from use_crc32 of the first token of a subpacket. After a frame-end marker 2 or 4
// trailer bytes are collected and checked against the residue. Cancel, timeout,
// carrier loss and debris close the subpacket at once; a data byte beyond the
// max_length limit (clamped to 8192) closes it with a too-long status. Rate: one token
// per clock while res takes results; a result waiting in a full result register stalls
// tok. A token is held in the input register, and its result is then loaded into the
// result register, which drives res. The byte-wise CRC update between them is the
// deepest path. max_length is written through cfg_we/cfg_wdata, by the user only while
// the block is idle (the block does not enforce this); it comes up as 1024 after reset.
`include "zmodem_subpacket_receiver_defines.svh"

module zmodem_subpacket_receiver import zsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	zsr_tok_if.sink          tok,
	zsr_res_if.source        res,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	// byte-wise reflected crc-32 update
	function automatic logic [31:0] fold32(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// byte-wise crc-16/xmodem update
	function automatic logic [15:0] fold16(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'd0};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
		end
		return c;
	endfunction

	// configuration
	logic [CNT_W-1:0] max_length_q;
	logic [CNT_W-1:0] limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	assign limit = (max_length_q > MAX_PAYLOAD_C) ? MAX_PAYLOAD_C : max_length_q;

	// input register stage
	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [7:0]        value_s1;
	logic [END_W-1:0]  end_type_s1;
	logic              use_crc32_s1;
	logic              advance;
	logic              slot_free;
	logic              has_res;

	assign slot_free = !res.valid || res.ready;
	// the token in the input register retires when its result has a place to go, or when it gives no result
	assign advance   = valid_s1 && (slot_free || !has_res);
	assign tok.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tok.valid && tok.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok.valid && tok.ready) begin
			func_s1      <= tok.func;
			value_s1     <= tok.value;
			end_type_s1  <= tok.end_type;
			use_crc32_s1 <= tok.use_crc32;
		end
	end

	// subpacket state
	phase_t           phase_q;
	logic [31:0]      crc_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       trail_q;
	logic [END_W-1:0] saved_q;
	logic             mode32_q;

	// state as seen by the current token: an idle block starts a fresh subpacket
	logic             start;
	phase_t           ph_cur;
	logic             mode_cur;
	logic [31:0]      crc_cur;
	logic [CNT_W-1:0] count_cur;
	logic [2:0]       trail_cur;
	logic [END_W-1:0] saved_cur;

	always_comb begin
		start     = (phase_q == PH_IDLE);
		ph_cur    = start ? PH_DATA : phase_q;
		mode_cur  = start ? use_crc32_s1 : mode32_q;
		crc_cur   = start ? (use_crc32_s1 ? CRC32_INIT : 32'd0) : crc_q;
		count_cur = start ? '0 : count_q;
		trail_cur = start ? 3'd0 : trail_q;
		saved_cur = start ? '0 : saved_q;
	end

	// crc of the byte in hand, data or frame-end mark
	logic [7:0]  fold_in;
	logic [31:0] crc_fold;

	always_comb begin
		fold_in = (func_s1 == FN_END) ? (MARK_BASE + {6'd0, end_type_s1}) : value_s1;
		if (mode_cur) begin
			crc_fold = fold32(crc_cur, fold_in);
		end else begin
			crc_fold = {16'd0, fold16(crc_cur[15:0], fold_in)};
		end
	end

	// next state and result
	phase_t           phase_d;
	logic [31:0]      crc_d;
	logic [CNT_W-1:0] count_d;
	logic [2:0]       trail_d;
	logic [END_W-1:0] saved_d;
	kind_t            kind_d;
	logic [END_W-1:0] fend_d;
	logic             last_d;
	logic [2:0]       trail_dec;
	logic             crc_good;

	always_comb begin
		trail_dec = (trail_cur != 3'd0) ? (trail_cur - 3'd1) : trail_cur;
		crc_good  = mode_cur ? (crc_fold == RESIDUE32) : (crc_fold[15:0] == 16'd0);
		phase_d   = ph_cur;
		crc_d     = crc_cur;
		count_d   = count_cur;
		trail_d   = trail_cur;
		saved_d   = saved_cur;
		has_res   = 1'b1;
		kind_d    = K_DEBRIS;
		fend_d    = '0;
		last_d    = 1'b1;
		case (func_s1)
			FN_DATA: begin
				if (ph_cur == PH_TRAIL) begin
					crc_d   = crc_fold;
					trail_d = trail_dec;
					if (trail_dec != 3'd0) begin
						has_res = 1'b0;
					end else if (crc_good) begin
						kind_d = K_END_OK;
						fend_d = saved_cur;
					end else begin
						kind_d = K_CRC_ERR;
					end
				end else if (count_cur >= limit) begin
					kind_d = K_TOO_LONG;
				end else begin
					count_d = count_cur + 1'b1;
					crc_d   = crc_fold;
					kind_d  = K_PAYLOAD;
					last_d  = 1'b0;
				end
			end
			FN_END: begin
				// marker restarts the trailer even if one is under way
				crc_d   = crc_fold;
				saved_d = end_type_s1;
				trail_d = mode_cur ? 3'd4 : 3'd2;
				phase_d = PH_TRAIL;
				has_res = 1'b0;
			end
			FN_CANCEL:  kind_d = K_CANCEL;
			FN_TIMEOUT: kind_d = K_TIMEOUT;
			FN_CARRIER: kind_d = K_CARRIER;
			default:    kind_d = K_DEBRIS;
		endcase
		// a closing result returns the block to idle
		if (has_res && last_d) begin
			phase_d = PH_IDLE;
			trail_d = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			crc_q    <= 32'd0;
			count_q  <= '0;
			trail_q  <= 3'd0;
			saved_q  <= '0;
			mode32_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			count_q  <= count_d;
			trail_q  <= trail_d;
			saved_q  <= saved_d;
			mode32_q <= mode_cur;
		end
	end

	// result register
	logic             res_valid_q;
	kind_t            kind_q;
	logic [7:0]       data_q;
	logic [END_W-1:0] fend_q;
	logic [CNT_W-1:0] bcount_q;
	logic             last_q;
	logic             load_res;

	assign load_res = advance && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			kind_q   <= kind_d;
			data_q   <= last_d ? 8'd0 : value_s1;
			fend_q   <= fend_d;
			bcount_q <= last_d ? count_cur : '0;
			last_q   <= last_d;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.kind       = kind_q;
	assign res.data_byte  = data_q;
	assign res.frame_end  = fend_q;
	assign res.byte_count = bcount_q;
	assign res.last       = last_q;

	// checks
	`ZSR_ASSERT_NOW(a_last_vs_kind, res_valid_q, ((kind_q == K_PAYLOAD) != last_q), "last flag disagrees with result kind")
	`ZSR_ASSERT_NOW(a_fend_only_ok, res_valid_q && (kind_q != K_END_OK), (fend_q == '0), "frame end on a result that is not end ok")
	`ZSR_ASSERT_NOW(a_trail_pending, (phase_q == PH_TRAIL), (trail_q != 3'd0), "trailer phase with no bytes left")
	`ZSR_ASSERT_NOW(a_count_bound, 1'b1, (count_q <= MAX_PAYLOAD_C), "payload count beyond the largest subpacket")
	`ZSR_ASSERT_NEXT(a_token_held, valid_s1 && has_res && !slot_free, valid_s1, "token dropped while result register was full")

endmodule
